[rtl/mcas_pkg.sv]
// Shared types and constants of the minimum-cost assignment solver.
package mcas_pkg;

  localparam int unsigned CostBits  = 48;
  localparam int unsigned TotalBits = 56;
  localparam int unsigned WordBits  = 64;

  // Cost level of an infinite entry, and the saturation bounds of the result.
  localparam logic [WordBits-1:0] InfLevel  = 64'd1000000000000000;
  localparam logic [WordBits-1:0] WordMax   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [WordBits-1:0] OutMax    = 64'h007F_FFFF_FFFF_FFFF;
  localparam logic [WordBits-1:0] OutMin    = 64'hFF80_0000_0000_0000;

  typedef struct packed {
    logic [5:0]                 row_index;
    logic [5:0]                 col_index;
    logic signed [CostBits-1:0] entry_cost;
    logic                       entry_infinite;
    logic                       last_entry;
  } in_req_t;

  typedef struct packed {
    logic signed [TotalBits-1:0] total_cost;
    logic                        infeasible;
  } out_rsp_t;

endpackage

[rtl/min_cost_assignment_solver_top.sv]
// Minimum-cost assignment solver: cost matrix load and Hungarian method sequencer.
//
// Usage: the input channel carries one cost matrix entry per request (row, column,
// signed cost, infinite flag, last flag). Entries are stored in a cost memory at one
// request per cycle. The request flagged last is stored too and then starts a solve
// over the matrix_size by matrix_size corner of the matrix; no request is taken while
// the solve runs. The result (minimum total cost and an infeasible flag) is held in an
// output register until the output channel takes it. Further entries are accepted while
// it waits, but a last entry waits until the previous result has been taken.
// A solve runs a clearing pass, then per row a slack reset and up to n+1 search steps,
// each a column scan over the cost and column memories followed by a potential update,
// then the path unwinding. Reset returns to the load state with matrix_size 64
// and no result pending; the cost memory holds whatever it held until entries are
// written again.
module min_cost_assignment_solver_top #(
  parameter int unsigned MAX_SIZE = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mcas_pkg::in_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mcas_pkg::out_rsp_t out_rsp_o,
  input  logic              cfg_we_i,
  input  logic [6:0]        cfg_wdata_i
);
  import mcas_pkg::*;

  localparam int unsigned IW  = $clog2(MAX_SIZE + 1);
  localparam int unsigned KW  = $clog2(MAX_SIZE + 2);
  localparam int unsigned CAW = $clog2(MAX_SIZE * MAX_SIZE);
  localparam int unsigned CW  = CostBits + 1;

  typedef struct packed {
    logic [WordBits-1:0] colp;
    logic [IW-1:0]       owner;
    logic [IW-1:0]       link;
    logic [WordBits-1:0] slack;
  } col_t;

  typedef enum logic [9:0] {
    S_LOAD  = 10'b00_0000_0001,
    S_CLR   = 10'b00_0000_0010,
    S_RINIT = 10'b00_0000_0100,
    S_STEP  = 10'b00_0000_1000,
    S_RROW  = 10'b00_0001_0000,
    S_SCAN  = 10'b00_0010_0000,
    S_UPD   = 10'b00_0100_0000,
    S_CHK   = 10'b00_1000_0000,
    S_AUG   = 10'b01_0000_0000,
    S_FIN   = 10'b10_0000_0000
  } state_e;

  // Memories.
  logic [CW-1:0]       cost_mem [MAX_SIZE*MAX_SIZE];
  col_t                col_mem  [MAX_SIZE+1];
  logic [WordBits-1:0] rowp_mem [MAX_SIZE+1];

  logic [CW-1:0]       cost_rd_q;
  col_t                col_rd_q;
  logic [WordBits-1:0] rowp_rd_q;

  logic                cost_we, col_we, rowp_we;
  logic [CAW-1:0]      cost_waddr, cost_raddr;
  logic [CW-1:0]       cost_wdata;
  logic [IW-1:0]       col_waddr, col_raddr, rowp_waddr, rowp_raddr;
  col_t                col_wdata;
  logic [WordBits-1:0] rowp_wdata;

  always_ff @(posedge clk_i) begin
    cost_rd_q <= cost_mem[cost_raddr];
    if (cost_we) begin
      cost_mem[cost_waddr] <= cost_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    col_rd_q <= col_mem[col_raddr];
    if (col_we) begin
      col_mem[col_waddr] <= col_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rowp_rd_q <= rowp_mem[rowp_raddr];
    if (rowp_we) begin
      rowp_mem[rowp_waddr] <= rowp_wdata;
    end
  end

  // Control and datapath registers.
  state_e              state_q, state_d;
  logic [1:0]          ph_q, ph_d;
  logic [IW-1:0]       j_q, j_d, i_q, i_d, cur_q, cur_d, r_q, r_d, best_q, best_d;
  logic [IW-1:0]       prev_q, prev_d;
  logic [KW-1:0]       k_q, k_d;
  logic                found_q, found_d;
  logic [WordBits-1:0] delta_q, delta_d, rp_q, rp_d, t_q, t_d, s_q, s_d;
  col_t                cw_q, cw_d;
  logic [MAX_SIZE:0]   used_q, used_d;
  logic [6:0]          size_q;
  logic                out_valid_q, out_valid_d;
  out_rsp_t            out_q, out_d;

  logic [IW-1:0]       n;
  logic                in_accept;
  logic [WordBits-1:0] cost_val, c_val, total, new_rowp;
  logic [IW-1:0]       owner_rd, link_rd;
  logic                scan_found, scan_last;

  assign n = (size_q > MAX_SIZE) ? IW'(MAX_SIZE) : IW'(size_q);

  assign in_ready_o  = (state_q == S_LOAD) && (!out_valid_q || !in_req_i.last_entry);
  assign in_accept   = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  assign cost_val = cost_rd_q[CW-1] ? InfLevel
                                    : WordBits'($signed(cost_rd_q[CostBits-1:0]));
  assign c_val    = t_q - col_rd_q.colp;
  assign total    = '0 - col_rd_q.colp;
  assign new_rowp = rowp_rd_q + delta_q;
  assign owner_rd = col_rd_q.owner;
  assign link_rd  = col_rd_q.link;

  assign scan_found = found_q || ($signed(s_q) < $signed(delta_q));
  assign scan_last  = (j_q == n);

  always_comb begin
    state_d     = state_q;
    ph_d        = ph_q;
    j_d         = j_q;
    i_d         = i_q;
    cur_d       = cur_q;
    r_d         = r_q;
    best_d      = best_q;
    prev_d      = prev_q;
    k_d         = k_q;
    found_d     = found_q;
    delta_d     = delta_q;
    rp_d        = rp_q;
    t_d         = t_q;
    s_d         = s_q;
    cw_d        = cw_q;
    used_d      = used_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    cost_we    = 1'b0;
    cost_waddr = CAW'(in_req_i.row_index) * CAW'(MAX_SIZE) + CAW'(in_req_i.col_index);
    cost_wdata = {in_req_i.entry_infinite, in_req_i.entry_cost};
    cost_raddr = CAW'(r_q - 1'b1) * CAW'(MAX_SIZE) + CAW'(j_q - 1'b1);
    col_we     = 1'b0;
    col_waddr  = j_q;
    col_wdata  = col_rd_q;
    col_raddr  = j_q;
    rowp_we    = 1'b0;
    rowp_waddr = j_q;
    rowp_wdata = '0;
    rowp_raddr = r_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_LOAD: begin
        if (in_accept) begin
          cost_we = (in_req_i.row_index < MAX_SIZE) && (in_req_i.col_index < MAX_SIZE);
          if (in_req_i.last_entry) begin
            state_d = S_CLR;
            j_d     = '0;
          end
        end
      end

      S_CLR: begin
        col_we    = 1'b1;
        col_wdata = '0;
        rowp_we   = 1'b1;
        if (j_q == n) begin
          ph_d = '0;
          if (n == '0) begin
            state_d = S_FIN;
          end else begin
            i_d     = IW'(1);
            j_d     = '0;
            used_d  = '0;
            state_d = S_RINIT;
          end
        end else begin
          j_d = j_q + 1'b1;
        end
      end

      S_RINIT: begin
        if (ph_q == 2'd0) begin
          ph_d = 2'd1;
        end else begin
          col_we          = 1'b1;
          col_wdata.owner = (j_q == '0) ? i_q : owner_rd;
          col_wdata.link  = '0;
          col_wdata.slack = InfLevel;
          ph_d            = 2'd0;
          if (scan_last) begin
            cur_d   = '0;
            state_d = S_STEP;
          end else begin
            j_d = j_q + 1'b1;
          end
        end
      end

      S_STEP: begin
        col_raddr = cur_q;
        if (ph_q == 2'd0) begin
          used_d[cur_q] = 1'b1;
          ph_d          = 2'd1;
        end else begin
          ph_d = 2'd0;
          if (owner_rd == '0 || owner_rd > n) begin
            k_d     = '0;
            state_d = S_AUG;
          end else begin
            r_d     = owner_rd;
            state_d = S_RROW;
          end
        end
      end

      S_RROW: begin
        if (ph_q == 2'd0) begin
          ph_d = 2'd1;
        end else begin
          rp_d    = rowp_rd_q;
          j_d     = IW'(1);
          delta_d = WordMax;
          found_d = 1'b0;
          ph_d    = 2'd0;
          state_d = S_SCAN;
        end
      end

      S_SCAN: begin
        // A used column is skipped; others take read, subtract,
        // slack update and minimum compare.
        if (ph_q == 2'd0 && used_q[j_q]) begin
          if (scan_last) begin
            j_d     = '0;
            state_d = found_q ? S_UPD : S_AUG;
            k_d     = '0;
          end else begin
            j_d = j_q + 1'b1;
          end
        end else begin
          case (ph_q)
            2'd0: ph_d = 2'd1;
            2'd1: begin
              t_d  = cost_val - rp_q;
              ph_d = 2'd2;
            end
            2'd2: begin
              col_we = 1'b1;
              s_d    = col_rd_q.slack;
              if ($signed(c_val) < $signed(col_rd_q.slack)) begin
                col_wdata.slack = c_val;
                col_wdata.link  = cur_q;
                s_d             = c_val;
              end
              ph_d = 2'd3;
            end
            default: begin
              if ($signed(s_q) < $signed(delta_q)) begin
                delta_d = s_q;
                best_d  = j_q;
                found_d = 1'b1;
              end
              ph_d = 2'd0;
              if (scan_last) begin
                j_d     = '0;
                k_d     = '0;
                state_d = scan_found ? S_UPD : S_AUG;
              end else begin
                j_d = j_q + 1'b1;
              end
            end
          endcase
        end
      end

      S_UPD: begin
        case (ph_q)
          2'd0: ph_d = 2'd1;
          2'd1: begin
            col_we = 1'b1;
            if (used_q[j_q]) begin
              col_wdata.colp = col_rd_q.colp - delta_q;
              rowp_raddr     = owner_rd;
            end else begin
              col_wdata.slack = col_rd_q.slack - delta_q;
            end
            if (used_q[j_q] && owner_rd <= n) begin
              ph_d = 2'd2;
            end else begin
              ph_d = 2'd0;
              if (scan_last) begin
                cur_d   = best_q;
                state_d = S_CHK;
              end else begin
                j_d = j_q + 1'b1;
              end
            end
          end
          default: begin
            rowp_we    = 1'b1;
            rowp_waddr = owner_rd;
            rowp_wdata = new_rowp;
            ph_d       = 2'd0;
            if (scan_last) begin
              cur_d   = best_q;
              state_d = S_CHK;
            end else begin
              j_d = j_q + 1'b1;
            end
          end
        endcase
      end

      S_CHK: begin
        col_raddr = cur_q;
        if (ph_q == 2'd0) begin
          ph_d = 2'd1;
        end else begin
          ph_d = 2'd0;
          if (owner_rd == '0) begin
            k_d     = '0;
            state_d = S_AUG;
          end else begin
            state_d = S_STEP;
          end
        end
      end

      S_AUG: begin
        col_raddr = cur_q;
        case (ph_q)
          2'd0: begin
            if (k_q > KW'(n) || cur_q == '0) begin
              if (i_q == n) begin
                state_d = S_FIN;
              end else begin
                i_d     = i_q + 1'b1;
                j_d     = '0;
                used_d  = '0;
                state_d = S_RINIT;
              end
            end else begin
              ph_d = 2'd1;
            end
          end
          2'd1: begin
            cw_d      = col_rd_q;
            prev_d    = (link_rd > n) ? '0 : link_rd;
            col_raddr = (link_rd > n) ? '0 : link_rd;
            ph_d      = 2'd2;
          end
          default: begin
            col_we          = 1'b1;
            col_waddr       = cur_q;
            col_wdata       = cw_q;
            col_wdata.owner = owner_rd;
            cur_d           = prev_q;
            k_d             = k_q + 1'b1;
            ph_d            = 2'd0;
          end
        endcase
      end

      S_FIN: begin
        col_raddr = '0;
        if (ph_q == 2'd0) begin
          ph_d = 2'd1;
        end else begin
          ph_d        = 2'd0;
          out_valid_d = 1'b1;
          out_d.infeasible = ($signed(total) >= $signed(InfLevel));
          if ($signed(total) >= $signed(InfLevel)) begin
            out_d.total_cost = '0;
          end else if ($signed(total) < $signed(OutMin)) begin
            out_d.total_cost = OutMin[TotalBits-1:0];
          end else if ($signed(total) > $signed(OutMax)) begin
            out_d.total_cost = OutMax[TotalBits-1:0];
          end else begin
            out_d.total_cost = total[TotalBits-1:0];
          end
          state_d = S_LOAD;
        end
      end

      default: begin
        state_d = S_LOAD;
        ph_d    = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      ph_q        <= '0;
      size_q      <= 7'd64;
      out_valid_q <= 1'b0;
      used_q      <= '0;
      found_q     <= 1'b0;
      j_q         <= '0;
      i_q         <= '0;
      cur_q       <= '0;
      k_q         <= '0;
    end else begin
      state_q     <= state_d;
      ph_q        <= ph_d;
      out_valid_q <= out_valid_d;
      used_q      <= used_d;
      found_q     <= found_d;
      j_q         <= j_d;
      i_q         <= i_d;
      cur_q       <= cur_d;
      k_q         <= k_d;
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    r_q     <= r_d;
    best_q  <= best_d;
    prev_q  <= prev_d;
    delta_q <= delta_d;
    rp_q    <= rp_d;
    t_q     <= t_d;
    s_q     <= s_d;
    cw_q    <= cw_d;
    out_q   <= out_d;
  end

endmodule

[tb/sv/tb_top.sv]
// Testbench for the minimum-cost assignment solver: loads cost matrices, checks totals.
`timescale 1ns / 100ps

module tb_top;
  import mcas_pkg::*;

  localparam int      MaxSize   = 64;
  localparam int      IdleLimit = 200000;
  localparam int      LongHold  = 3000;
  localparam longint  InfCost   = 64'sd1000000000000000;
  localparam longint  TotHi     = 64'sh007F_FFFF_FFFF_FFFF;
  localparam longint  TotLo     = 64'shFF80_0000_0000_0000;
  localparam longint  LongMax   = 64'sh7FFF_FFFF_FFFF_FFFF;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid    = 1'b0;
  logic     in_ready;
  in_req_t  in_req      = '0;
  logic     out_valid;
  logic     out_ready   = 1'b0;
  out_rsp_t out_rsp;
  logic     cfg_we      = 1'b0;
  logic [6:0] cfg_wdata = '0;

  min_cost_assignment_solver_top #(.MAX_SIZE(MaxSize)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Model of the block: cost matrix and the configured size.
  longint   cost_mem [MaxSize][MaxSize];
  int       size_reg = 64;

  in_req_t  entry_queue [$];
  out_rsp_t total_queue [$];
  int       errors = 0;
  bit       calm_phase = 0;
  int       hold_reqs = 0;
  bit       in_acc = 0;

  task automatic report_mismatch(input string what);
    errors++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  function automatic longint assignment_cost(input int n);
    longint u [MaxSize+1];
    longint v [MaxSize+1];
    longint slack [MaxSize+1];
    int     owner [MaxSize+1];
    int     link [MaxSize+1];
    bit     used [MaxSize+1];
    int     cur, r, best, o, prev;
    bit     found;
    longint delta, c;
    for (int j = 0; j <= MaxSize; j++) begin
      u[j] = 0; v[j] = 0; owner[j] = 0; link[j] = 0;
    end
    for (int i = 1; i <= n; i++) begin
      cur = 0;
      owner[0] = i;
      for (int j = 0; j <= n; j++) begin
        slack[j] = InfCost; used[j] = 0; link[j] = 0;
      end
      for (int k = 0; k <= n; k++) begin
        r = owner[cur];
        best = 0;
        found = 0;
        delta = LongMax;
        used[cur] = 1;
        if (r < 1 || r > n) break;
        for (int j = 1; j <= n; j++) begin
          if (!used[j]) begin
            c = cost_mem[r-1][j-1] - u[r] - v[j];
            if (c < slack[j]) begin
              slack[j] = c;
              link[j] = cur;
            end
            if (slack[j] < delta) begin
              delta = slack[j];
              best = j;
              found = 1;
            end
          end
        end
        if (!found) break;
        for (int j = 0; j <= n; j++) begin
          if (used[j]) begin
            o = owner[j];
            if (o <= n) u[o] = u[o] + delta;
            v[j] = v[j] - delta;
          end else begin
            slack[j] = slack[j] - delta;
          end
        end
        cur = best;
        if (owner[cur] == 0) break;
      end
      for (int k = 0; k <= n && cur != 0; k++) begin
        prev = link[cur];
        if (prev > n) prev = 0;
        owner[cur] = owner[prev];
        cur = prev;
      end
    end
    return 64'sd0 - v[0];
  endfunction

  // Stores one accepted entry and queues the expected total when it starts a solve.
  task automatic predict_entry(input in_req_t e);
    longint   c, tot;
    out_rsp_t r;
    c = {{16{e.entry_cost[CostBits-1]}}, e.entry_cost};
    if (e.entry_infinite) c = InfCost;
    cost_mem[e.row_index][e.col_index] = c;
    if (e.last_entry) begin
      tot = assignment_cost(size_reg > MaxSize ? MaxSize : size_reg);
      r.infeasible = (tot >= InfCost);
      if (r.infeasible) tot = 0;
      else if (tot < TotLo) tot = TotLo;
      else if (tot > TotHi) tot = TotHi;
      r.total_cost = tot[TotalBits-1:0];
      total_queue = {total_queue, r};
    end
  endtask

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (calm_phase || p < 60) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Driver.
  int send_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_acc) begin
        // Hold the request until it is taken.
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (entry_queue.size() > 0) begin
        in_req   <= entry_queue.pop_front();
        in_valid <= 1'b1;
        send_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver.
  int hold_seen = 0;
  int stall_cnt = 0;
  always @(negedge clk_i) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_seen + 1;
      stall_cnt <= LongHold;
      out_ready <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_ni;
      if (!calm_phase && $urandom_range(0, 3) == 0) stall_cnt <= pick_gap();
    end
  end

  // Monitor and watchdog.
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    out_rsp_t want;
    in_acc <= in_valid && in_ready;
    if (in_valid && in_ready) predict_entry(in_req);
    if (out_valid && out_ready) begin
      if (total_queue.size() == 0) begin
        report_mismatch("result with no solve pending");
      end else begin
        want = total_queue.pop_front();
        if (out_rsp.total_cost !== want.total_cost)
          report_mismatch($sformatf("total_cost got %0d want %0d",
                                    out_rsp.total_cost, want.total_cost));
        if (out_rsp.infeasible !== want.infeasible)
          report_mismatch($sformatf("infeasible got %0b want %0b",
                                    out_rsp.infeasible, want.infeasible));
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no progress for %0d cycles", IdleLimit);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [CostBits-1:0] random_cost();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return CostBits'($signed($urandom_range(0, 200)) - 100);
    if (p < 65) return $urandom_range(0, 1) ? {1'b1, {(CostBits-1){1'b0}}}
                                            : {1'b0, {(CostBits-1){1'b1}}};
    if (p < 80) return CostBits'({$urandom(), $urandom()});
    return CostBits'($signed($urandom_range(0, 2000000)) - 1000000);
  endfunction

  function automatic in_req_t make_entry(input int r, input int c, input bit inf_ok);
    in_req_t e;
    e.row_index      = r[5:0];
    e.col_index      = c[5:0];
    e.entry_cost     = random_cost();
    e.entry_infinite = inf_ok && ($urandom_range(0, 9) == 0);
    e.last_entry     = 1'b0;
    return e;
  endfunction

  task automatic wait_idle();
    while (entry_queue.size() > 0 || in_valid || total_queue.size() > 0) @(negedge clk_i);
    // A plain entry leaves no result to wait for; give it time to be stored.
    repeat (20) @(negedge clk_i);
  endtask

  task automatic set_size(input int value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value[6:0];
    size_reg = value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Fills the whole n-by-n corner in random order, then extra entries with solves among them.
  task automatic load_matrix(input int n, input int extra, input bit inf_ok);
    in_req_t e;
    in_req_t corner [$];
    int      k;
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++) corner = {corner, make_entry(r, c, inf_ok)};
    corner.shuffle();
    foreach (corner[i]) entry_queue = {entry_queue, corner[i]};
    for (int i = 0; i < extra; i++) begin
      if (n > 0 && $urandom_range(0, 3) != 0)
        e = make_entry($urandom_range(0, n - 1), $urandom_range(0, n - 1), inf_ok);
      else
        e = make_entry($urandom_range(0, 63), $urandom_range(0, 63), inf_ok);
      e.last_entry = ($urandom_range(0, 5) == 0);
      entry_queue = {entry_queue, e};
    end
    k = $urandom_range(0, 1);
    e = make_entry(k ? n - 1 : 0, 0, inf_ok);
    if (n == 0) e = make_entry(0, 0, inf_ok);
    e.last_entry = 1'b1;
    entry_queue = {entry_queue, e};
  endtask

  initial begin
    in_req_t e;
    int      n;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: extreme sizes, extreme costs, infinite entries.
    set_size(127);
    set_size(1);
    e = '0; e.entry_cost = {1'b1, {(CostBits-1){1'b0}}}; e.last_entry = 1'b1;
    entry_queue = {entry_queue, e};
    e.entry_cost = {1'b0, {(CostBits-1){1'b1}}};
    entry_queue = {entry_queue, e};
    e.entry_infinite = 1'b1;
    entry_queue = {entry_queue, e};
    set_size(0);
    e = '0; e.row_index = 6'd63; e.col_index = 6'd63; e.last_entry = 1'b1;
    entry_queue = {entry_queue, e};
    set_size(2);
    for (int r = 0; r < 2; r++)
      for (int c = 0; c < 2; c++) begin
        e = '0; e.row_index = r[5:0]; e.col_index = c[5:0]; e.entry_infinite = 1'b1;
        e.last_entry = (r == 1 && c == 1);
        entry_queue = {entry_queue, e};
      end
    for (int r = 0; r < 2; r++)
      for (int c = 0; c < 2; c++) begin
        e = '0; e.row_index = r[5:0]; e.col_index = c[5:0];
        e.entry_cost = {1'b1, {(CostBits-1){1'b0}}};
        e.entry_infinite = (r == 0 && c == 1);
        e.last_entry = (r == 1 && c == 1);
        entry_queue = {entry_queue, e};
      end
    set_size(64);
    set_size(3);
    load_matrix(3, 2, 1'b1);

    // Back-pressure: the receiver stalls long while several solves are requested.
    wait_idle();
    hold_reqs = hold_reqs + 1;
    load_matrix(3, 12, 1'b0);
    for (int i = 0; i < 3; i++) begin
      e = make_entry(0, 0, 1'b0); e.last_entry = 1'b1;
      entry_queue = {entry_queue, e};
    end

    for (int phase = 0; phase < 27; phase++) begin
      n = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
      if ($urandom_range(0, 9) == 0) n = 8;
      set_size(n);
      calm_phase = ($urandom_range(0, 5) == 0);
      load_matrix(n, $urandom_range(0, 8), $urandom_range(0, 2) == 0);
    end

    wait_idle();
    repeat (100) @(negedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[min_cost_assignment_solver_top.f]
rtl/mcas_pkg.sv
rtl/min_cost_assignment_solver_top.sv
tb/sv/tb_top.sv
